@@ hdl/alpha_texture_blitter_core_macros.svh @@
// Assertion macros used by the alpha texture blitter core
`ifndef ALPHA_TEXTURE_BLITTER_CORE_MACROS_SVH
`define ALPHA_TEXTURE_BLITTER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// When the condition holds, the consequence holds in the same cycle
`define ATB_ASSERT_IMPLIES(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (cons)) \
        else $error("atb assertion failed");

// When the condition holds, the consequence holds in the next cycle
`define ATB_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (cons)) \
        else $error("atb assertion failed");

// The condition never holds
`define ATB_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("atb assertion failed");

`else

`define ATB_ASSERT_IMPLIES(label, clk, rst_n, cond, cons)
`define ATB_ASSERT_NEXT(label, clk, rst_n, cond, cons)
`define ATB_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

@@ hdl/atb_pkg.sv @@
// Shared types, constants and the channel blend function of the alpha texture blitter
`timescale 1ns / 1ps

package atb_pkg;

    // Default frame and texture dimension limits
    localparam int FRAME_DIM_MAX_DEF = 256;
    localparam int TEX_DIM_MAX_DEF   = 256;

    // Field widths
    localparam int CH_W        = 8;
    localparam int COORD_W     = 8;
    localparam int DIM_REG_W   = 9;
    localparam int ORG_W       = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 9;
    localparam int PIX_W       = 4 * CH_W;

    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'd0;

    // Output queue sizing
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_ORIGIN_X     = 3'd2,
        REG_ORIGIN_Y     = 3'd3,
        REG_TEX_WIDTH    = 3'd4,
        REG_TEX_HEIGHT   = 3'd5,
        REG_HAS_ALPHA    = 3'd6
    } t_cfg_reg;

    // Request kinds
    typedef enum logic {
        REQ_BLIT = 1'b0,
        REQ_READ = 1'b1
    } t_req;

    // Stored pixel, red in the low byte
    typedef struct packed {
        logic [CH_W-1:0] alpha;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } t_pix;

    // Item state carried from address generation to the blend stage
    typedef struct packed {
        logic               is_read;
        logic               in_frame;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CH_W-1:0]    red;
        logic [CH_W-1:0]    green;
        logic [CH_W-1:0]    blue;
        logic [CH_W-1:0]    alpha;
    } t_s1_info;

    // One result item
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        t_pix               pix;
        logic               is_read;
    } t_result;

    // ((a+1)*src + (255-a)*dst) >> 8
    function automatic logic [CH_W-1:0] mix_channel(
        input logic [CH_W-1:0] src,
        input logic [CH_W-1:0] dst,
        input logic [CH_W-1:0] a
    );
        logic [CH_W:0]    a_inc;
        logic [CH_W-1:0]  a_inv;
        logic [16:0]      p_src;
        logic [16:0]      p_dst;
        logic [16:0]      sum;
        a_inc = {1'b0, a} + 9'd1;
        a_inv = ALPHA_OPAQUE - a;
        p_src = 17'(a_inc) * 17'(src);
        p_dst = 17'(a_inv) * 17'(dst);
        sum   = p_src + p_dst;
        return sum[15:8];
    endfunction

endpackage

@@ hdl/alpha_texture_blitter_core.sv @@
// Alpha texture blitter: one item per clock while the input is not stalled; an
// accepted item that produces a result reads its frame pixel from the
// single-port-read frame memory in the accept cycle; in the next cycle a blit
// item blends and writes it back, and the result goes into the output queue.
// Consecutive texels that hit the same pixel are forwarded, so the rate stays
// at one item per cycle as long as the output is taken; the four-entry result
// queue sets how far the output may stall before the input is stalled. After
// reset the frame memory is cleared one pixel per cycle over all FRAME_DIM_MAX *
// FRAME_DIM_MAX entries (65536 at the default size), during which no item is
// accepted; configuration writes are taken at any time.
`timescale 1ns / 1ps
`include "alpha_texture_blitter_core_macros.svh"

module alpha_texture_blitter_core #(
    parameter int FRAME_DIM_MAX = atb_pkg::FRAME_DIM_MAX_DEF,
    parameter int TEX_DIM_MAX   = atb_pkg::TEX_DIM_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration
    input  logic                           i_cfg_we,
    input  logic [atb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [atb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_req_type,
    input  logic                           i_first_texel,
    input  logic [atb_pkg::CH_W-1:0]       i_src_red,
    input  logic [atb_pkg::CH_W-1:0]       i_src_green,
    input  logic [atb_pkg::CH_W-1:0]       i_src_blue,
    input  logic [atb_pkg::CH_W-1:0]       i_src_alpha,
    input  logic [atb_pkg::COORD_W-1:0]    i_read_x,
    input  logic [atb_pkg::COORD_W-1:0]    i_read_y,
    // Output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [atb_pkg::COORD_W-1:0]    o_pix_x,
    output logic [atb_pkg::COORD_W-1:0]    o_pix_y,
    output logic [atb_pkg::CH_W-1:0]       o_pix_red,
    output logic [atb_pkg::CH_W-1:0]       o_pix_green,
    output logic [atb_pkg::CH_W-1:0]       o_pix_blue,
    output logic [atb_pkg::CH_W-1:0]       o_pix_alpha,
    output logic                           o_is_read
);
    import atb_pkg::*;

    localparam int AW = $clog2(FRAME_DIM_MAX * FRAME_DIM_MAX);

    logic                  in_accept;
    logic                  clearing;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    t_pix                  rd_data;
    logic                  s1_valid;
    logic [AW-1:0]         s1_addr;
    t_s1_info              s1_info;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    t_pix                  wr_data;
    logic                  push;
    t_result               result;
    t_result               head;
    logic [OUTQ_CNT_W-1:0] q_count;

    // Hold input while clearing or while the queue could not take every item in flight
    assign o_in_stall = clearing
                     || ((q_count + OUTQ_CNT_W'(s1_valid)) > OUTQ_CNT_W'(OUTQ_DEPTH - 1));
    assign in_accept  = i_in_valid && !o_in_stall;

    atb_addr_gen #(
        .FRAME_DIM_MAX (FRAME_DIM_MAX),
        .TEX_DIM_MAX   (TEX_DIM_MAX)
    ) u_addr_gen (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (in_accept),
        .i_req_type    (i_req_type),
        .i_first_texel (i_first_texel),
        .i_src_red     (i_src_red),
        .i_src_green   (i_src_green),
        .i_src_blue    (i_src_blue),
        .i_src_alpha   (i_src_alpha),
        .i_read_x      (i_read_x),
        .i_read_y      (i_read_y),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .o_s1_valid    (s1_valid),
        .o_s1_addr     (s1_addr),
        .o_s1_info     (s1_info)
    );

    atb_frame_ram #(
        .FRAME_DIM_MAX (FRAME_DIM_MAX)
    ) u_frame_ram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_data  (rd_data),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data),
        .o_clearing (clearing)
    );

    atb_blend #(
        .FRAME_DIM_MAX (FRAME_DIM_MAX)
    ) u_blend (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .i_s1_valid (s1_valid),
        .i_s1_addr  (s1_addr),
        .i_s1_info  (s1_info),
        .i_mem_data (rd_data),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_push     (push),
        .o_result   (result)
    );

    atb_out_q u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (result),
        .i_pop   (!i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (head),
        .o_count (q_count)
    );

    // Drive the result fields from the queue head
    assign o_pix_x     = head.x;
    assign o_pix_y     = head.y;
    assign o_pix_red   = head.pix.red;
    assign o_pix_green = head.pix.green;
    assign o_pix_blue  = head.pix.blue;
    assign o_pix_alpha = head.pix.alpha;
    assign o_is_read   = head.is_read;

    // The queue never takes an item while full
    `ATB_ASSERT_NEVER(a_q_overflow, i_clk, i_rst_n, push && (q_count == OUTQ_CNT_W'(OUTQ_DEPTH)))
    // No pipeline write overlaps the clearing sweep
    `ATB_ASSERT_NEVER(a_wr_in_clear, i_clk, i_rst_n, clearing && wr_en)
    // An accepted item that produces a result reaches the blend stage next cycle
    `ATB_ASSERT_NEXT(a_s1_follow, i_clk, i_rst_n, rd_en, s1_valid)
    // Every blit write report carries an opaque alpha
    `ATB_ASSERT_IMPLIES(a_blit_opaque, i_clk, i_rst_n, o_out_valid && !o_is_read, o_pix_alpha == ALPHA_OPAQUE)

endmodule

@@ hdl/atb_frame_ram.sv @@
// Frame store memory with registered read and a clearing sweep after reset
`timescale 1ns / 1ps

module atb_frame_ram #(
    parameter int FRAME_DIM_MAX = atb_pkg::FRAME_DIM_MAX_DEF
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_rd_en,
    input  logic [$clog2(FRAME_DIM_MAX*FRAME_DIM_MAX)-1:0]    i_rd_addr,
    output atb_pkg::t_pix                                     o_rd_data,
    input  logic                                              i_wr_en,
    input  logic [$clog2(FRAME_DIM_MAX*FRAME_DIM_MAX)-1:0]    i_wr_addr,
    input  atb_pkg::t_pix                                     i_wr_data,
    output logic                                              o_clearing
);
    import atb_pkg::*;

    localparam int DEPTH = FRAME_DIM_MAX * FRAME_DIM_MAX;
    localparam int AW    = $clog2(DEPTH);

    logic [PIX_W-1:0] mem [0:DEPTH-1];
    logic [AW-1:0]    r_clr_addr;
    logic             r_clearing;
    t_pix             r_rd_data;

    // Sweep every entry once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Write port: clearing sweep has priority
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= t_pix'(mem[i_rd_addr]);
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

@@ hdl/atb_addr_gen.sv @@
// Configuration registers, texel walk, clipping and frame address generation
`timescale 1ns / 1ps

module atb_addr_gen #(
    parameter int FRAME_DIM_MAX = atb_pkg::FRAME_DIM_MAX_DEF,
    parameter int TEX_DIM_MAX   = atb_pkg::TEX_DIM_MAX_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_cfg_we,
    input  logic [atb_pkg::CFG_IDX_W-1:0]                  i_cfg_idx,
    input  logic [atb_pkg::CFG_DATA_W-1:0]                 i_cfg_data,
    input  logic                                           i_accept,
    input  logic                                           i_req_type,
    input  logic                                           i_first_texel,
    input  logic [atb_pkg::CH_W-1:0]                       i_src_red,
    input  logic [atb_pkg::CH_W-1:0]                       i_src_green,
    input  logic [atb_pkg::CH_W-1:0]                       i_src_blue,
    input  logic [atb_pkg::CH_W-1:0]                       i_src_alpha,
    input  logic [atb_pkg::COORD_W-1:0]                    i_read_x,
    input  logic [atb_pkg::COORD_W-1:0]                    i_read_y,
    output logic                                           o_rd_en,
    output logic [$clog2(FRAME_DIM_MAX*FRAME_DIM_MAX)-1:0] o_rd_addr,
    output logic                                           o_s1_valid,
    output logic [$clog2(FRAME_DIM_MAX*FRAME_DIM_MAX)-1:0] o_s1_addr,
    output atb_pkg::t_s1_info                              o_s1_info
);
    import atb_pkg::*;

    localparam int DEPTH = FRAME_DIM_MAX * FRAME_DIM_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam int X_W   = $clog2(FRAME_DIM_MAX);
    localparam int FD_W  = $clog2(FRAME_DIM_MAX + 1);
    localparam int TC_W  = $clog2(TEX_DIM_MAX);
    localparam int TD_W  = $clog2(TEX_DIM_MAX + 1);
    localparam int PX_W  = ((TD_W > ORG_W) ? TD_W : ORG_W) + 1;
    localparam int CW0   = (PX_W > FD_W) ? PX_W : FD_W;
    localparam int CW    = (CW0 > DIM_REG_W) ? CW0 : DIM_REG_W;

    logic [DIM_REG_W-1:0] r_frame_width;
    logic [DIM_REG_W-1:0] r_frame_height;
    logic [ORG_W-1:0]     r_origin_x;
    logic [ORG_W-1:0]     r_origin_y;
    logic [DIM_REG_W-1:0] r_tex_width;
    logic [DIM_REG_W-1:0] r_tex_height;
    logic                 r_has_alpha;

    logic [TC_W-1:0]      r_col;
    logic [TD_W-1:0]      r_row;
    logic [TC_W-1:0]      n_col;
    logic [TD_W-1:0]      n_row;

    logic                 r_s1_valid;
    logic [AW-1:0]        r_s1_addr;
    t_s1_info             r_s1_info;

    logic [CW-1:0]        fw_c, fh_c, tw_c, th_c, tw_raw, th_raw;
    logic [TC_W-1:0]      col_e;
    logic [TD_W-1:0]      row_e;
    logic [CW-1:0]        col_inc;
    logic                 wrap;
    logic                 done;
    logic [CW-1:0]        px_c, py_c, rx_c, ry_c;
    logic                 blit_inside;
    logic                 read_inside;
    logic                 is_rd;
    logic [CH_W-1:0]      a_eff;
    logic [X_W-1:0]       col_idx, row_idx;
    logic [AW-1:0]        addr;
    logic                 produce;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 9'd256;
            r_frame_height <= 9'd256;
            r_origin_x     <= '0;
            r_origin_y     <= '0;
            r_tex_width    <= 9'd1;
            r_tex_height   <= 9'd1;
            r_has_alpha    <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                REG_ORIGIN_X:     r_origin_x     <= i_cfg_data[ORG_W-1:0];
                REG_ORIGIN_Y:     r_origin_y     <= i_cfg_data[ORG_W-1:0];
                REG_TEX_WIDTH:    r_tex_width    <= i_cfg_data;
                REG_TEX_HEIGHT:   r_tex_height   <= i_cfg_data;
                REG_HAS_ALPHA:    r_has_alpha    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Saturate the frame and texture sizes, forcing a zero texture size to one
    always_comb begin
        fw_c   = (CW'(r_frame_width) > CW'(FRAME_DIM_MAX)) ? CW'(FRAME_DIM_MAX)
                                                           : CW'(r_frame_width);
        fh_c   = (CW'(r_frame_height) > CW'(FRAME_DIM_MAX)) ? CW'(FRAME_DIM_MAX)
                                                            : CW'(r_frame_height);
        tw_raw = CW'(r_tex_width);
        th_raw = CW'(r_tex_height);
        if (tw_raw > CW'(TEX_DIM_MAX)) begin
            tw_c = CW'(TEX_DIM_MAX);
        end else if (tw_raw == '0) begin
            tw_c = CW'(1);
        end else begin
            tw_c = tw_raw;
        end
        if (th_raw > CW'(TEX_DIM_MAX)) begin
            th_c = CW'(TEX_DIM_MAX);
        end else if (th_raw == '0) begin
            th_c = CW'(1);
        end else begin
            th_c = th_raw;
        end
    end

    // Texel position, clipping and address
    always_comb begin
        is_rd   = (t_req'(i_req_type) == REQ_READ);
        col_e   = i_first_texel ? '0 : r_col;
        row_e   = i_first_texel ? '0 : r_row;
        done    = (CW'(row_e) >= th_c) || (CW'(col_e) >= tw_c);
        col_inc = CW'(col_e) + CW'(1);
        wrap    = (col_inc >= tw_c);
        n_col   = wrap ? '0 : col_inc[TC_W-1:0];
        n_row   = wrap ? row_e + TD_W'(1) : row_e;

        px_c        = CW'(r_origin_x) + CW'(col_e);
        py_c        = CW'(r_origin_y) + CW'(row_e);
        rx_c        = CW'(i_read_x);
        ry_c        = CW'(i_read_y);
        blit_inside = (px_c < fw_c) && (py_c < fh_c);
        read_inside = (rx_c < fw_c) && (ry_c < fh_c);
        a_eff       = r_has_alpha ? i_src_alpha : ALPHA_OPAQUE;

        col_idx = is_rd ? rx_c[X_W-1:0] : px_c[X_W-1:0];
        row_idx = is_rd ? ry_c[X_W-1:0] : py_c[X_W-1:0];
        addr    = AW'(row_idx) * AW'(FRAME_DIM_MAX) + AW'(col_idx);
        produce = is_rd || (!done && blit_inside && (a_eff != ALPHA_CLEAR));
    end

    // Advance the texel position on each accepted blit item; it holds once the walk is done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept && !is_rd) begin
            r_col <= done ? col_e : n_col;
            r_row <= done ? row_e : n_row;
        end
    end

    // Stage register toward the blend stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_accept && produce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_addr           <= addr;
            r_s1_info.is_read   <= is_rd;
            r_s1_info.in_frame  <= read_inside;
            r_s1_info.x         <= is_rd ? i_read_x : px_c[COORD_W-1:0];
            r_s1_info.y         <= is_rd ? i_read_y : py_c[COORD_W-1:0];
            r_s1_info.red       <= i_src_red;
            r_s1_info.green     <= i_src_green;
            r_s1_info.blue      <= i_src_blue;
            r_s1_info.alpha     <= a_eff;
        end
    end

    assign o_rd_en    = i_accept && produce;
    assign o_rd_addr  = addr;
    assign o_s1_valid = r_s1_valid;
    assign o_s1_addr  = r_s1_addr;
    assign o_s1_info  = r_s1_info;

endmodule

@@ hdl/atb_blend.sv @@
// Read-modify-write stage: forwarding, per-channel blend and write-back
`timescale 1ns / 1ps

module atb_blend #(
    parameter int FRAME_DIM_MAX = atb_pkg::FRAME_DIM_MAX_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_rd_en,
    input  logic [$clog2(FRAME_DIM_MAX*FRAME_DIM_MAX)-1:0] i_rd_addr,
    input  logic                                           i_s1_valid,
    input  logic [$clog2(FRAME_DIM_MAX*FRAME_DIM_MAX)-1:0] i_s1_addr,
    input  atb_pkg::t_s1_info                              i_s1_info,
    input  atb_pkg::t_pix                                  i_mem_data,
    output logic                                           o_wr_en,
    output logic [$clog2(FRAME_DIM_MAX*FRAME_DIM_MAX)-1:0] o_wr_addr,
    output atb_pkg::t_pix                                  o_wr_data,
    output logic                                           o_push,
    output atb_pkg::t_result                               o_result
);
    import atb_pkg::*;

    logic r_fwd_hit;
    t_pix r_fwd_data;
    t_pix dst;
    t_pix new_pix;

    // Pick the latest value of the pixel and form the result
    always_comb begin
        dst = r_fwd_hit ? r_fwd_data : i_mem_data;
        if (i_s1_info.is_read) begin
            new_pix = i_s1_info.in_frame ? dst : '0;
        end else if (i_s1_info.alpha == ALPHA_OPAQUE) begin
            new_pix.red   = i_s1_info.red;
            new_pix.green = i_s1_info.green;
            new_pix.blue  = i_s1_info.blue;
            new_pix.alpha = ALPHA_OPAQUE;
        end else begin
            new_pix.red   = mix_channel(i_s1_info.red, dst.red, i_s1_info.alpha);
            new_pix.green = mix_channel(i_s1_info.green, dst.green, i_s1_info.alpha);
            new_pix.blue  = mix_channel(i_s1_info.blue, dst.blue, i_s1_info.alpha);
            new_pix.alpha = ALPHA_OPAQUE;
        end
    end

    assign o_wr_en   = i_s1_valid && !i_s1_info.is_read;
    assign o_wr_addr = i_s1_addr;
    assign o_wr_data = new_pix;

    // Forward a write that lands on the entry being read in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= o_wr_en && i_rd_en && (i_s1_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= new_pix;
    end

    assign o_push           = i_s1_valid;
    assign o_result.x       = i_s1_info.x;
    assign o_result.y       = i_s1_info.y;
    assign o_result.pix     = new_pix;
    assign o_result.is_read = i_s1_info.is_read;

endmodule

@@ hdl/atb_out_q.sv @@
// Small result queue that decouples the pipeline from the output stall
`timescale 1ns / 1ps

module atb_out_q (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  atb_pkg::t_result               i_data,
    input  logic                           i_pop,
    output logic                           o_valid,
    output atb_pkg::t_result               o_data,
    output logic [atb_pkg::OUTQ_CNT_W-1:0] o_count
);
    import atb_pkg::*;

    t_result                 r_entries [0:OUTQ_DEPTH-1];
    logic [OUTQ_PTR_W-1:0]   r_wr_ptr;
    logic [OUTQ_PTR_W-1:0]   r_rd_ptr;
    logic [OUTQ_CNT_W-1:0]   r_count;
    logic                    do_pop;

    assign do_pop = i_pop && (r_count != '0);

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + OUTQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + OUTQ_PTR_W'(1);
            end
            r_count <= r_count + OUTQ_CNT_W'(i_push) - OUTQ_CNT_W'(do_pop);
        end
    end

    // Store the pushed item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_entries[r_rd_ptr];
    assign o_count = r_count;

endmodule
